### rtl/odq_pkg.sv
// Shared types and constants for the ordered deque with search.
// Used by odq_ctrl, odq_datapath and ordered_deque_with_search.
package odq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = $clog2(DEPTH + 1);
    // Wide enough to hold the raw match count and the saturation limit.
    localparam int SUM_W = (LEN_W > 5) ? LEN_W : 6;
    localparam int CNT_MAX = 31;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_DELETE     = 3'd4,
        REQ_COUNT      = 3'd5,
        REQ_READ       = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_FINISH = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } odq_cmd_t;

endpackage

### rtl/ordered_deque_with_search.sv
// Ordered deque with search, top level: controller plus datapath.
// Depends on odq_pkg, odq_ctrl and odq_datapath.
//
// Holds up to DEPTH (16) signed words, front at position 0, and serves one
// request at a time: push or pop at either end, delete the first entry equal
// to a value, count entries equal to a value, or read a position. Each
// request gives exactly one result. The accept edge registers the request and
// compares every entry against the value in parallel; the finishing edge
// updates the store through a one-place shift network and loads the result
// register. The finishing edge waits while an earlier result is still untaken
// at the output, and a new request is taken in the cycle after a request
// finishes. Pushes into a full store are dropped with status full; pops from
// an empty store change nothing and report status empty.
module ordered_deque_with_search import odq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [4:0]         match_count,
    output logic               hit,
    output logic [1:0]         status
);

    odq_cmd_t cmd;

    odq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    odq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .read_value  (read_value),
        .match_count (match_count),
        .hit         (hit),
        .status      (status)
    );

endmodule

### rtl/odq_ctrl.sv
// Controller for the ordered deque: request sequencing and result valid.
// Depends on odq_pkg.
module odq_ctrl import odq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output odq_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.finish || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished request did not raise out_valid");

    a_accept_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> in_stall)
        else $error("new request taken while one is in flight");

    a_wait_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && out_stall) |=> state_reg == S_FINISH)
        else $error("request finished over an untaken result");

endmodule

### rtl/odq_datapath.sv
// Datapath for the ordered deque: entry store, length, compare vector,
// shift network and result register. Depends on odq_pkg.
module odq_datapath import odq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  odq_cmd_t           cmd,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic signed [31:0] read_value,
    output logic [4:0]         match_count,
    output logic               hit,
    output logic [1:0]         status
);

    logic [31:0]      entries_reg [DEPTH];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [2:0]       req_reg;
    logic [31:0]      val_reg;
    logic [7:0]       pos_reg;
    logic [DEPTH-1:0] match_reg;

    logic signed [31:0] read_value_reg, read_value_next;
    logic [4:0]         match_count_reg, match_count_next;
    logic               hit_reg, hit_next;
    logic [1:0]         status_reg, status_next;

    logic [DEPTH-1:0] at_or_after;
    logic [SUM_W-1:0] cnt_sum;
    logic             any_match;
    logic             full;
    logic             empty;
    logic             pos_in;

    assign full      = (len_reg == LEN_W'(DEPTH));
    assign empty     = (len_reg == '0);
    assign any_match = |match_reg;
    assign pos_in    = (9'(pos_reg) < 9'(len_reg));

    // Registered request and compare vector, taken at accept.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_type;
            val_reg <= value;
            pos_reg <= position;
            for (int i = 0; i < DEPTH; i++)
            begin
                match_reg[i] <= (entries_reg[i] == value) && (LEN_W'(i) < len_reg);
            end
        end
    end

    // Shift mask for delete and the match count.
    always_comb
    begin
        at_or_after[0] = match_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            at_or_after[i] = at_or_after[i-1] | match_reg[i];
        end
        cnt_sum = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            cnt_sum = cnt_sum + SUM_W'(match_reg[i]);
        end
    end

    always_comb
    begin
        len_next         = len_reg;
        read_value_next  = '0;
        match_count_next = '0;
        hit_next         = 1'b0;
        status_next      = ST_OK;
        priority case (req_reg)
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    len_next = len_reg + LEN_W'(1);
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    len_next = len_reg - LEN_W'(1);
            end
            REQ_DELETE:
            begin
                hit_next = any_match;
                if (any_match)
                    len_next = len_reg - LEN_W'(1);
            end
            REQ_COUNT:
            begin
                if (cnt_sum > SUM_W'(CNT_MAX))
                    match_count_next = 5'(CNT_MAX);
                else
                    match_count_next = cnt_sum[4:0];
            end
            REQ_READ:
            begin
                hit_next = pos_in;
                if (pos_in)
                    read_value_next = entries_reg[pos_reg[IDX_W-1:0]];
                else
                    read_value_next = -32'sd1;
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cmd.finish)
            len_reg <= len_next;
    end

    // Store update: write at the back, or shift the line one place (from the first match onward for delete).
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            priority case (req_reg)
                REQ_PUSH_BACK:
                begin
                    if (!full)
                        entries_reg[len_reg[IDX_W-1:0]] <= val_reg;
                end
                REQ_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        for (int i = 1; i < DEPTH; i++)
                            entries_reg[i] <= entries_reg[i-1];
                        entries_reg[0] <= val_reg;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!empty)
                        for (int i = 0; i < DEPTH - 1; i++)
                            entries_reg[i] <= entries_reg[i+1];
                end
                REQ_DELETE:
                begin
                    // close the gap from the first match onward
                    for (int i = 0; i < DEPTH - 1; i++)
                        if (at_or_after[i])
                            entries_reg[i] <= entries_reg[i+1];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_value_reg  <= read_value_next;
            match_count_reg <= match_count_next;
            hit_reg         <= hit_next;
            status_reg      <= status_next;
        end
    end

    assign read_value  = read_value_reg;
    assign match_count = match_count_reg;
    assign hit         = hit_reg;
    assign status      = status_reg;

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(DEPTH))
        else $error("length beyond capacity");

    a_full_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && full && (req_reg == REQ_PUSH_BACK || req_reg == REQ_PUSH_FRONT))
        |=> (len_reg == LEN_W'(DEPTH)) && (status_reg == ST_FULL))
        else $error("push into a full store was not dropped");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && req_reg == REQ_DELETE && any_match)
        |=> (len_reg == $past(len_reg) - LEN_W'(1)) && hit_reg)
        else $error("delete hit did not remove one entry");

endmodule
